// ===== hdl/wctl_pkg.sv =====
// ----------------------------------------------------------------------------
// wctl_pkg
// Shared types and constants for the word count table lookup block.
// ----------------------------------------------------------------------------
package wctl_pkg;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// stop word that switches from build to lookup phase
	localparam logic [7:0] END_C0 = 8'h65; // 'e'
	localparam logic [7:0] END_C1 = 8'h6E; // 'n'
	localparam logic [7:0] END_C2 = 8'h64; // 'd'

	typedef enum logic [2:0] {
		ST_NEW  = 3'd0,
		ST_DUP  = 3'd1,
		ST_END  = 3'd2,
		ST_HIT  = 3'd3,
		ST_MISS = 3'd4,
		ST_FULL = 3'd5,
		ST_LONG = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SEARCH
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;       // take one character
		logic    clr_search; // rewind the table scan
		logic    run_search; // scan one entry per cycle
		logic    finish;     // close the word and emit a result
		status_t fin_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic overlong;
		logic lookup;
		logic is_end;
		logic match;
		logic exhausted;
		logic full;
	} dp_sts_t;

endpackage

// ===== hdl/word_count_table_lookup.sv =====
// ----------------------------------------------------------------------------
// word_count_table_lookup
// Word frequency table with a build phase and a lookup phase.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter one per item on char_code/last_char, taken when start is
//   high and busy is low. A character that is not the last leaves busy low.
//   The last character of a word starts its processing; busy stays high for
//   its classification and, when a table scan is needed, for the scan, which
//   ends at a match or once every stored entry has been read, at once on an
//   empty table. The scan reads one table row per cycle from a memory with
//   a single read port.
//   In the cycle after processing ends, done pulses for one cycle with status,
//   occurrences, entry_index and hits_total. Every finished word gives one
//   result; other characters give none. The receiver cannot stall: a result
//   is valid only in its done cycle (hits_total tracks the running total).
//   Reset clears the word buffer, the entry count, the phase and the hit
//   total; the table rows need no clearing since only filled rows are read.
// ----------------------------------------------------------------------------
module word_count_table_lookup
	import wctl_pkg::*;
#(
	parameter int WORD_CAP      = 32,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] occurrences,
	output logic [7:0]  entry_index,
	output logic [15:0] hits_total
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	wctl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_char (last_char),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	wctl_dp #(
		.WORD_CAP      (WORD_CAP),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.char_code   (char_code),
		.sts         (sts),
		.done        (done),
		.status      (status),
		.occurrences (occurrences),
		.entry_index (entry_index),
		.hits_total  (hits_total)
	);

endmodule

// ===== hdl/wctl_ctrl.sv =====
// ----------------------------------------------------------------------------
// wctl_ctrl
// Controller: sequences character intake, word classification and the
// table scan, and tells the datapath which result to produce.
// ----------------------------------------------------------------------------
module wctl_ctrl
	import wctl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_char,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.fin_status = ST_NEW;
		busy           = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (last_char) begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				if (sts.overlong) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_LONG;
					state_d        = S_IDLE;
				end else if (!sts.lookup && sts.is_end) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_END;
					state_d        = S_IDLE;
				end else begin
					cmd.clr_search = 1'b1;
					state_d        = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.run_search = 1'b1;
				if (sts.match) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = sts.lookup ? ST_HIT : ST_DUP;
					state_d        = S_IDLE;
				end else if (sts.exhausted) begin
					cmd.finish = 1'b1;
					if (sts.lookup) begin
						cmd.fin_status = ST_MISS;
					end else if (sts.full) begin
						cmd.fin_status = ST_FULL;
					end else begin
						cmd.fin_status = ST_NEW;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/wctl_dp.sv =====
// ----------------------------------------------------------------------------
// wctl_dp
// Datapath: word buffer, entry table memory with one-entry-per-cycle scan,
// counters and the result register.
// ----------------------------------------------------------------------------
module wctl_dp
	import wctl_pkg::*;
#(
	parameter int WORD_CAP      = 32,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  char_code,
	output dp_sts_t     sts,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] occurrences,
	output logic [7:0]  entry_index,
	output logic [15:0] hits_total
);

	localparam int KEY_MAX = WORD_CAP - 1;
	localparam int KB      = KEY_MAX * 8;
	localparam int LW      = $clog2(WORD_CAP);
	localparam int RW      = 16 + LW + KB;
	localparam int AW      = $clog2(TABLE_ENTRIES);
	localparam int CW      = $clog2(TABLE_ENTRIES + 1);

	// row layout: {count, length, key bytes}
	logic [RW-1:0] tbl_q [TABLE_ENTRIES];

	logic [KB-1:0] buf_q;
	logic [LW-1:0] len_q;
	logic          ovl_q;
	logic          lookup_q;
	logic [CW-1:0] used_q;
	logic [15:0]   hits_q;

	logic [CW-1:0] rd_addr_q;
	logic          pend_s1;
	logic [AW-1:0] pend_idx_s1;
	logic [RW-1:0] row_s1;

	logic          done_q;
	logic [2:0]    status_q;
	logic [15:0]   occ_q;
	logic [7:0]    idx_q;

	logic [15:0]   row_cnt;
	logic [LW-1:0] row_len;
	logic [KB-1:0] row_key;
	logic [15:0]   cnt_inc;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [RW-1:0] wr_data;
	logic [AW+7:0] pend_idx_ext;
	logic [AW+7:0] used_idx_ext;

	assign row_cnt = row_s1[RW-1 -: 16];
	assign row_len = row_s1[KB +: LW];
	assign row_key = row_s1[KB-1:0];
	assign cnt_inc = (row_cnt != COUNT_MAX) ? row_cnt + 16'd1 : row_cnt;

	assign pend_idx_ext = {8'd0, pend_idx_s1};
	assign used_idx_ext = {8'd0, used_q[AW-1:0]};

	assign sts.overlong  = ovl_q;
	assign sts.lookup    = lookup_q;
	assign sts.is_end    = (len_q == LW'(3)) && (buf_q[7:0] == END_C0) &&
	                       (buf_q[15:8] == END_C1) && (buf_q[23:16] == END_C2);
	assign sts.match     = pend_s1 && (row_len == len_q) && (row_key == buf_q);
	assign sts.exhausted = !pend_s1 && (rd_addr_q >= used_q);
	assign sts.full      = (used_q >= CW'(TABLE_ENTRIES));

	// table write: duplicate bumps the matched row, new word fills the next row
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pend_idx_s1;
		wr_data = {cnt_inc, row_len, row_key};
		if (cmd.finish && cmd.fin_status == ST_DUP) begin
			wr_en = 1'b1;
		end else if (cmd.finish && cmd.fin_status == ST_NEW) begin
			wr_en   = 1'b1;
			wr_addr = used_q[AW-1:0];
			wr_data = {16'd1, len_q, buf_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_search && rd_addr_q < used_q) begin
			row_s1      <= tbl_q[rd_addr_q[AW-1:0]];
			pend_idx_s1 <= rd_addr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else if (cmd.clr_search) begin
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else if (cmd.run_search && rd_addr_q < used_q) begin
			rd_addr_q <= rd_addr_q + CW'(1);
			pend_s1   <= 1'b1;
		end else begin
			pend_s1 <= 1'b0;
		end
	end

	// word buffer; bytes past the length stay zero so whole rows compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			len_q <= '0;
			ovl_q <= 1'b0;
		end else if (cmd.finish) begin
			buf_q <= '0;
			len_q <= '0;
			ovl_q <= 1'b0;
		end else if (cmd.load) begin
			if (len_q < LW'(KEY_MAX)) begin
				for (int i = 0; i < KEY_MAX; i++) begin
					if (len_q == LW'(i)) begin
						buf_q[i*8 +: 8] <= char_code;
					end
				end
				len_q <= len_q + LW'(1);
			end else begin
				ovl_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_q <= 1'b0;
			used_q   <= '0;
			hits_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish && cmd.fin_status == ST_END) begin
				lookup_q <= 1'b1;
			end
			if (cmd.finish && cmd.fin_status == ST_NEW) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.finish && cmd.fin_status == ST_HIT && hits_q != COUNT_MAX) begin
				hits_q <= hits_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			occ_q    <= '0;
			idx_q    <= '0;
			case (cmd.fin_status)
				ST_HIT: begin
					occ_q <= row_cnt;
					idx_q <= pend_idx_ext[7:0];
				end
				ST_DUP: begin
					occ_q <= cnt_inc;
					idx_q <= pend_idx_ext[7:0];
				end
				ST_NEW: begin
					occ_q <= 16'd1;
					idx_q <= used_idx_ext[7:0];
				end
				default: begin
					occ_q <= '0;
					idx_q <= '0;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign occurrences = occ_q;
	assign entry_index = idx_q;
	assign hits_total  = hits_q;

endmodule

// ===== hdl/wctl_chk.sv =====
// ----------------------------------------------------------------------------
// wctl_chk
// Port-level checks for the word count table lookup block.
// ----------------------------------------------------------------------------
module wctl_chk
	import wctl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last_char,
	input logic        done,
	input logic [2:0]  status,
	input logic [15:0] occurrences,
	input logic [7:0]  entry_index
);

	// a final character always starts word processing
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_char |=> busy)
		else $error("last character did not raise busy");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 3'd7)
		else $error("undefined status code");

	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_MISS || status == ST_FULL || status == ST_LONG ||
		         status == ST_END) |-> occurrences == 16'd0 && entry_index == 8'd0)
		else $error("entry data on a result without an entry");

	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NEW |-> occurrences == 16'd1)
		else $error("new entry count is not one");

endmodule

bind word_count_table_lookup wctl_chk u_chk (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the word count table lookup block. Words go in one character per
// item and every finished word is checked against a predicted result. The run
// covers the build phase, duplicates, a full table, overlong words, long runs
// of one repeated word, the stop word and the lookup phase.
// ----------------------------------------------------------------------------
module testbench;
	import wctl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_CAP      = 32;
	localparam int TABLE_ENTRIES = 256;
	localparam int KEY_MAX       = WORD_CAP - 1;
	localparam int MAX_GAP       = 40;
	localparam int QUIET_LIMIT   = 4 * (MAX_GAP + TABLE_ENTRIES + 8);
	localparam int TAIL_CYCLES   = TABLE_ENTRIES + 8;
	localparam int REPEAT_RUN    = 20;
	localparam int VOCAB_SIZE    = 12;
	localparam int MAX_REPORTS   = 20;

	typedef logic [7:0] byte_q_t [$];

	typedef struct {
		logic [7:0] code;
		logic       last;
		bit         drain;  // hold this item until every result is in
		int         gap;    // idle cycles before it goes out
	} char_item_t;

	typedef struct {
		status_t     status;
		logic [15:0] occ;
		logic [7:0]  idx;
		logic [15:0] hits;
	} word_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  char_code = '0;
	logic        last_char = 1'b0;
	logic        done;
	logic [2:0]  status;
	logic [15:0] occurrences;
	logic [7:0]  entry_index;
	logic [15:0] hits_total;

	char_item_t   pending_chars [$];
	word_result_t expected_results [$];
	int           items_total = 0;
	int           chars_taken = 0;
	int           words_owed = 0;
	int           results_taken = 0;
	int           quiet_cycles = 0;
	int           mismatches = 0;
	int           status_tally [7];
	bit           calm = 1'b0;

	// predicted block state
	logic [7:0]  word_buf [KEY_MAX];
	int          word_len = 0;
	bit          too_long = 1'b0;
	logic [7:0]  key_bytes [TABLE_ENTRIES][KEY_MAX];
	int          key_len [TABLE_ENTRIES];
	logic [15:0] key_count [TABLE_ENTRIES];
	int          keys_used = 0;
	bit          lookup_mode = 1'b0;
	logic [15:0] hit_sum = '0;

	word_count_table_lookup #(
		.WORD_CAP      (WORD_CAP),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.char_code   (char_code),
		.last_char   (last_char),
		.done        (done),
		.status      (status),
		.occurrences (occurrences),
		.entry_index (entry_index),
		.hits_total  (hits_total)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int locate_word();
		bit same;
		for (int i = 0; i < keys_used; i++) begin
			if (key_len[i] == word_len) begin
				same = 1'b1;
				for (int k = 0; k < word_len; k++)
					if (key_bytes[i][k] != word_buf[k])
						same = 1'b0;
				if (same)
					return i;
			end
		end
		return -1;
	endfunction

	// Takes one character; returns 1 with the expected result when it ends a word.
	function automatic bit tally_char(input logic [7:0] ch, input logic last,
	                                  output word_result_t res);
		int slot;
		res.status = ST_NEW;
		res.occ    = '0;
		res.idx    = '0;
		res.hits   = '0;
		if (word_len < KEY_MAX) begin
			word_buf[word_len] = ch;
			word_len++;
		end else
			too_long = 1'b1;
		if (!last)
			return 1'b0;
		if (too_long)
			res.status = ST_LONG;
		else if (lookup_mode) begin
			slot = locate_word();
			if (slot >= 0) begin
				res.status = ST_HIT;
				res.occ    = key_count[slot];
				res.idx    = slot[7:0];
				if (hit_sum != COUNT_MAX)
					hit_sum++;
			end else
				res.status = ST_MISS;
		end else if (word_len == 3 && word_buf[0] == END_C0 && word_buf[1] == END_C1 &&
		             word_buf[2] == END_C2) begin
			res.status  = ST_END;
			lookup_mode = 1'b1;
		end else begin
			slot = locate_word();
			if (slot >= 0) begin
				if (key_count[slot] != COUNT_MAX)
					key_count[slot]++;
				res.status = ST_DUP;
				res.occ    = key_count[slot];
				res.idx    = slot[7:0];
			end else if (keys_used < TABLE_ENTRIES) begin
				for (int k = 0; k < word_len; k++)
					key_bytes[keys_used][k] = word_buf[k];
				key_len[keys_used]   = word_len;
				key_count[keys_used] = 16'd1;
				res.status = ST_NEW;
				res.occ    = 16'd1;
				res.idx    = keys_used[7:0];
				keys_used++;
			end else
				res.status = ST_FULL;
		end
		res.hits = hit_sum;
		status_tally[res.status]++;
		word_len = 0;
		too_long = 1'b0;
		return 1'b1;
	endfunction

	function automatic byte_q_t random_word(input int len);
		byte_q_t w;
		repeat (len)
			w.insert(w.size(), 8'($urandom_range(1, 255)));
		return w;
	endfunction

	task automatic queue_word(input byte_q_t w, input bit drain);
		char_item_t item;
		int         r;
		for (int i = 0; i < w.size(); i++) begin
			r          = $urandom_range(0, 99);
			item.code  = w[i];
			item.last  = (i == w.size() - 1);
			item.drain = drain && (i == 0);
			if (calm || r < 60)
				item.gap = 0;
			else if (r < 90)
				item.gap = $urandom_range(1, 3);
			else
				item.gap = $urandom_range(8, MAX_GAP);
			pending_chars.insert(pending_chars.size(), item);
		end
	endtask

	// driver: presents items and predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		word_result_t res;
		char_item_t   item;
		logic         taken;
		logic         launch;
		if (!arst_n) begin
			start       <= 1'b0;
			char_code   <= '0;
			last_char   <= 1'b0;
			chars_taken <= 0;
			words_owed  <= 0;
		end else begin
			taken  = start && !busy;
			launch = 1'b0;
			if (taken) begin
				chars_taken <= chars_taken + 1;
				if (tally_char(char_code, last_char, res)) begin
					expected_results.insert(expected_results.size(), res);
					words_owed <= words_owed + 1;
				end
			end
			if (!start || taken) begin
				if (pending_chars.size() != 0) begin
					if (pending_chars[0].gap != 0)
						pending_chars[0].gap = pending_chars[0].gap - 1;
					else if (!pending_chars[0].drain ||
					         (!taken && words_owed == results_taken))
						launch = 1'b1;
				end
				if (launch) begin
					item = pending_chars.pop_front();
					char_code <= item.code;
					last_char <= item.last;
				end
				start <= launch;
			end
		end
	end

	// monitor: checks results in order and watches for a stall
	always @(posedge clk or negedge arst_n) begin
		word_result_t want;
		if (!arst_n) begin
			results_taken <= 0;
			quiet_cycles  <= 0;
		end else begin
			if (done) begin
				results_taken <= results_taken + 1;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result: status %0d occ %0d idx %0d hits %0d",
						         $time, status, occurrences, entry_index, hits_total);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || occurrences !== want.occ ||
					    entry_index !== want.idx || hits_total !== want.hits) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: expected status %0d occ %0d idx %0d hits %0d,",
							          " actual status %0d occ %0d idx %0d hits %0d"},
							         $time, want.status, want.occ, want.idx, want.hits,
							         status, occurrences, entry_index, hits_total);
					end
				end
			end
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item or result for %0d cycles", $time, quiet_cycles);
				$display("testbench: FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		byte_q_t    vocab [VOCAB_SIZE];
		byte_q_t    w;
		logic [7:0] singles [255];
		logic [7:0] tmp;
		int         r;
		int         j;
		int         words;

		vocab[0] = random_word(KEY_MAX);
		vocab[1] = random_word(WORD_CAP);
		for (int i = 2; i < VOCAB_SIZE; i++)
			vocab[i] = random_word($urandom_range(1, 8));

		// directed: slot 0, duplicates, byte extremes, zero byte, near misses of the stop word
		w = {8'h61};                          queue_word(w, 1'b0);
		w = {8'h61};                          queue_word(w, 1'b0);
		w = {8'h61, 8'h62};                   queue_word(w, 1'b0);
		w = {8'hFF};                          queue_word(w, 1'b0);
		w = {8'h01};                          queue_word(w, 1'b0);
		w = {8'h7A, 8'h00};                   queue_word(w, 1'b0);
		w = {END_C0, END_C1};                 queue_word(w, 1'b0);
		w = {END_C0, END_C1, END_C2, 8'h73};  queue_word(w, 1'b0);
		w = {END_C0, END_C1, 8'h44};          queue_word(w, 1'b0);
		w = {8'h62, 8'h61};                   queue_word(w, 1'b0);
		w = {8'h61, 8'h62};                   queue_word(w, 1'b0);
		queue_word(vocab[1], 1'b0);

		// build phase, mostly repeats of a small vocabulary
		for (int i = 0; i < 12; i++) begin
			calm = ($urandom_range(0, 7) == 0);
			r    = $urandom_range(0, 99);
			if (r < 55)
				w = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
			else if (r < 85)
				w = random_word($urandom_range(1, 10));
			else if (r < 93)
				w = random_word($urandom_range(WORD_CAP, WORD_CAP + 4));
			else
				w = random_word(KEY_MAX);
			queue_word(w, 1'b0);
		end

		// every single-byte word plus the two-byte words above overflow the table
		for (int i = 0; i < 255; i++)
			singles[i] = 8'(i + 1);
		for (int i = 254; i > 0; i--) begin
			j          = $urandom_range(0, i);
			tmp        = singles[i];
			singles[i] = singles[j];
			singles[j] = tmp;
		end
		for (int i = 0; i < 255; i++) begin
			calm = ($urandom_range(0, 7) == 0);
			w    = {singles[i]};
			queue_word(w, 1'b0);
		end

		// table full: new words are dropped, repeats still count
		for (int i = 0; i < 8; i++) begin
			calm = 1'b0;
			r    = $urandom_range(0, 3);
			if (r < 2)
				w = random_word($urandom_range(2, 6));
			else if (r == 2)
				w = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
			else
				w = {8'($urandom_range(1, 255))};
			queue_word(w, 1'b0);
		end

		// back-to-back repeats of slot 0
		calm = 1'b1;
		w    = {8'h61};
		for (int i = 0; i < REPEAT_RUN; i++)
			queue_word(w, i == 0);

		calm = 1'b0;
		w    = {END_C0, END_C1, END_C2};
		queue_word(w, 1'b1);
		queue_word(w, 1'b0);

		// lookup phase
		for (int i = 0; i < 16; i++) begin
			calm = ($urandom_range(0, 7) == 0);
			r    = $urandom_range(0, 99);
			if (r < 35)
				w = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
			else if (r < 55)
				w = {8'($urandom_range(1, 255))};
			else if (r < 75)
				w = random_word($urandom_range(2, 8));
			else if (r < 82)
				w = random_word($urandom_range(WORD_CAP, WORD_CAP + 4));
			else if (r < 90)
				w = {8'h61, 8'h62};
			else
				w = {END_C0, END_C1};
			queue_word(w, 1'b0);
		end

		// back-to-back hits on slot 0
		calm = 1'b1;
		w    = {8'h61};
		for (int i = 0; i < REPEAT_RUN; i++)
			queue_word(w, i == 0);
		calm = 1'b0;
		for (int i = 0; i < 3; i++) begin
			w = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
			queue_word(w, 1'b0);
		end

		items_total = pending_chars.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_taken != items_total || words_owed != results_taken)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		words = 0;
		foreach (status_tally[s])
			words += status_tally[s];
		$display("covered %0d characters in %0d words: %0d stored, %0d repeats, %0d stop words",
		         chars_taken, words, status_tally[ST_NEW], status_tally[ST_DUP],
		         status_tally[ST_END]);
		$display("%0d hits, %0d misses, %0d dropped on a full table, %0d overlong; %0d errors",
		         status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_FULL],
		         status_tally[ST_LONG], mismatches);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/wctl_pkg.sv
hdl/wctl_ctrl.sv
hdl/wctl_dp.sv
hdl/word_count_table_lookup.sv
hdl/wctl_chk.sv
test/testbench.sv
